@@ src/rtn_pkg.sv @@
package rtn_pkg;

  localparam int QueueDepth = 2;

  localparam logic [6:0] CH_I = 7'h49;
  localparam logic [6:0] CH_V = 7'h56;
  localparam logic [6:0] CH_X = 7'h58;
  localparam logic [6:0] CH_L = 7'h4C;
  localparam logic [6:0] CH_C = 7'h43;
  localparam logic [6:0] CH_D = 7'h44;
  localparam logic [6:0] CH_M = 7'h4D;
  localparam logic [11:0] MAX_VALID = 12'd3999;

  typedef enum logic [1:0] {
    SEL_ONE,
    SEL_FIVE,
    SEL_TEN
  } sel_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SPLIT,
    FR_PUSH
  } front_state_t;

  // classified value: decimal digits, units first
  typedef struct packed {
    logic            invalid;
    logic [3:0][3:0] digit;
  } entry_t;

  function automatic logic [13:0] pow10(input logic [1:0] place);
    logic [13:0] p;
    unique case (place)
      2'd3:    p = 14'd1000;
      2'd2:    p = 14'd100;
      2'd1:    p = 14'd10;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] pat_len(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd1, 4'd5:               n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9:   n = 3'd2;
      4'd3, 4'd7:               n = 3'd3;
      4'd8:                     n = 3'd4;
      default:                  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic sel_t pat_sel(input logic [3:0] d, input logic [1:0] k);
    sel_t s;
    s = SEL_ONE;
    unique case (d)
      4'd4:                     s = (k == 2'd1) ? SEL_FIVE : SEL_ONE;
      4'd5, 4'd6, 4'd7, 4'd8:   s = (k == 2'd0) ? SEL_FIVE : SEL_ONE;
      4'd9:                     s = (k == 2'd1) ? SEL_TEN : SEL_ONE;
      default:                  s = SEL_ONE;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] letter(input logic [1:0] place, input sel_t sel);
    logic [6:0] c;
    c = CH_M;
    unique case (place)
      2'd0: begin
        unique case (sel)
          SEL_ONE:  c = CH_I;
          SEL_FIVE: c = CH_V;
          SEL_TEN:  c = CH_X;
          default:  c = CH_I;
        endcase
      end
      2'd1: begin
        unique case (sel)
          SEL_ONE:  c = CH_X;
          SEL_FIVE: c = CH_L;
          SEL_TEN:  c = CH_C;
          default:  c = CH_X;
        endcase
      end
      2'd2: begin
        unique case (sel)
          SEL_ONE:  c = CH_C;
          SEL_FIVE: c = CH_D;
          SEL_TEN:  c = CH_M;
          default:  c = CH_C;
        endcase
      end
      default: c = CH_M;
    endcase
    return c;
  endfunction

endpackage

@@ src/rtn_front.sv @@
module rtn_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [11:0]     value,
  output logic            push_valid,
  input  logic            push_ready,
  output rtn_pkg::entry_t push_entry
);

  rtn_pkg::front_state_t state, state_next;
  logic [11:0]     rem;
  logic [1:0]      place;
  rtn_pkg::entry_t entry;

  logic [13:0] pw;
  logic [13:0] sub;
  logic [3:0]  dg;
  logic [11:0] rem_left;
  logic        in_bad;

  assign in_bad = (value == 12'd0) || (value > rtn_pkg::MAX_VALID);

  // one decimal place per cycle: parallel compares against its multiples
  always_comb begin
    pw  = rtn_pkg::pow10(place);
    dg  = '0;
    sub = '0;
    for (int k = 1; k < 10; k++) begin
      if ({2'b00, rem} >= 14'(k) * pw) begin
        dg  = 4'(k);
        sub = 14'(k) * pw;
      end
    end
    rem_left = rem - sub[11:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rtn_pkg::FR_IDLE: begin
        if (in_valid) begin
          state_next = in_bad ? rtn_pkg::FR_PUSH : rtn_pkg::FR_SPLIT;
        end
      end
      rtn_pkg::FR_SPLIT: begin
        if (place == 2'd1) begin
          state_next = rtn_pkg::FR_PUSH;
        end
      end
      rtn_pkg::FR_PUSH: begin
        if (push_ready) begin
          state_next = rtn_pkg::FR_IDLE;
        end
      end
      default: state_next = rtn_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == rtn_pkg::FR_IDLE);
    push_valid = (state == rtn_pkg::FR_PUSH);
    push_entry = entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtn_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rtn_pkg::FR_IDLE && in_valid) begin
      rem           <= value;
      place         <= 2'd3;
      entry.invalid <= in_bad;
      entry.digit   <= '0;
    end else if (state == rtn_pkg::FR_SPLIT) begin
      entry.digit[place] <= dg;
      rem                <= rem_left;
      place              <= place - 2'd1;
      if (place == 2'd1) begin
        entry.digit[0] <= rem_left[3:0];
      end
    end
  end

endmodule

@@ src/rtn_queue.sv @@
module rtn_queue #(
  parameter int DEPTH = rtn_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  rtn_pkg::entry_t wr_entry,
  output logic            rd_valid,
  input  logic            rd_ready,
  output rtn_pkg::entry_t rd_entry
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  rtn_pkg::entry_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready = (count != CntW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

@@ src/rtn_back.sv @@
module rtn_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  rtn_pkg::entry_t pop_entry,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [6:0]      symbol_char,
  output logic            last,
  output logic            invalid
);

  logic            busy;
  rtn_pkg::entry_t cur;
  logic [1:0]      place;
  logic [1:0]      k;

  logic [1:0]      start_place;
  logic [3:0]      d;
  logic            more;
  logic            found;
  logic [1:0]      np;
  logic            step;
  logic [6:0]      ch;

  assign pop_ready = !busy;
  assign step      = busy && (!out_valid || out_ready);

  always_comb begin
    start_place = 2'd0;
    for (int p = 0; p < 4; p++) begin
      if (pop_entry.digit[p] != 4'd0) begin
        start_place = 2'(p);
      end
    end
  end

  // current letter, whether its digit has more letters, and the next lower place that still has letters
  always_comb begin
    d     = cur.digit[place];
    more  = ({1'b0, k} + 3'd1) < rtn_pkg::pat_len(d);
    ch    = rtn_pkg::letter(place, rtn_pkg::pat_sel(d, k));
    found = 1'b0;
    np    = 2'd0;
    for (int p = 0; p < 3; p++) begin
      if (2'(p) < place && cur.digit[p] != 4'd0) begin
        found = 1'b1;
        np    = 2'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !step) begin
        out_valid <= 1'b0;
      end
      if (!busy && pop_valid) begin
        busy <= 1'b1;
      end else if (step) begin
        out_valid <= 1'b1;
        if (cur.invalid || (!more && !found)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && pop_valid) begin
      cur   <= pop_entry;
      place <= start_place;
      k     <= 2'd0;
    end else if (step) begin
      if (cur.invalid) begin
        symbol_char <= 7'd0;
        last        <= 1'b1;
        invalid     <= 1'b1;
      end else begin
        symbol_char <= ch;
        last        <= !more && !found;
        invalid     <= 1'b0;
        if (more) begin
          k <= k + 2'd1;
        end else begin
          place <= np;
          k     <= 2'd0;
        end
      end
    end
  end

endmodule

@@ src/integer_to_roman_numeral_core.sv @@
// path of a value: split, push, pop, output reg
// throughput: one character per cycle while the receiver is ready and the back end is
// busy with a numeral; the front splitter takes a new value only after pushing the last,
// the back end pops one only when idle, and a numeral has 1 to 15 characters
// the front splitter resolves one decimal place per cycle
// reset: synchronous, active high; clears the splitter, the queue and the output valid
module integer_to_roman_numeral_core #(
  parameter int QUEUE_DEPTH = rtn_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] symbol_char
  output logic        m_tlast,
  output logic        m_tuser    // [0] invalid
);

  logic            f_valid;
  logic            f_ready;
  rtn_pkg::entry_t f_entry;
  logic            q_valid;
  logic            q_ready;
  rtn_pkg::entry_t q_entry;
  logic [6:0]      symbol_char;

  rtn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .value      (s_tdata[11:0]),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_entry (f_entry)
  );

  rtn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_entry (f_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_entry (q_entry)
  );

  rtn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (q_valid),
    .pop_ready   (q_ready),
    .pop_entry   (q_entry),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .symbol_char (symbol_char),
    .last        (m_tlast),
    .invalid     (m_tuser)
  );

  assign m_tdata = {1'b0, symbol_char};

  a_invalid_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
    else $error("invalid item not a lone zero item");

  a_letter_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata != 8'd0))
    else $error("valid numeral item with zero char");

  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule
